/* rtl/sic_pkg.sv */
// ----------------------------------------------------------------------------
// sic_pkg
// Shared types and codes for the passing-siding interlocking controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sic_pkg;

  // occupancy bit masks
  localparam logic [7:0] OCC_E_ADJ = 8'h80;
  localparam logic [7:0] OCC_E_APP = 8'h40;
  localparam logic [7:0] OCC_W_ADJ = 8'h20;
  localparam logic [7:0] OCC_W_APP = 8'h10;
  localparam logic [7:0] OCC_MAIN  = 8'h08;
  localparam logic [7:0] OCC_SIDE  = 8'h04;
  localparam logic [7:0] OCC_E_OS  = 8'h02;
  localparam logic [7:0] OCC_W_OS  = 8'h01;

  // aspect codes, red bit high, green bit low
  localparam logic [1:0] ASP_RED    = 2'd2;
  localparam logic [1:0] ASP_YELLOW = 2'd3;
  localparam logic [1:0] ASP_GREEN  = 2'd1;
  localparam logic [7:0] LAMPS_ALL_RED = 8'hAA;

  // clearance codes
  localparam logic [1:0] CLR_NONE = 2'd0;
  localparam logic [1:0] CLR_EAST = 2'd1;
  localparam logic [1:0] CLR_WEST = 2'd2;

  // item kinds
  localparam logic [1:0] KIND_SCAN   = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_ROUTE  = 2'd2;
  localparam logic [1:0] KIND_REMOTE = 2'd3;

  // route code turn and clear commands
  localparam logic [1:0] TURN_MAIN    = 2'd1;
  localparam logic [1:0] TURN_DIV     = 2'd2;
  localparam logic [1:0] CMD_KEEP     = 2'd0;
  localparam logic [1:0] CMD_CLR_EAST = 2'd1;
  localparam logic [1:0] CMD_CLR_WEST = 2'd2;
  localparam logic [1:0] CMD_CANCEL   = 2'd3;

  // points pulse codes
  localparam logic [1:0] PULSE_NONE = 2'd0;
  localparam logic [1:0] PULSE_MAIN = 2'd1;
  localparam logic [1:0] PULSE_DIV  = 2'd2;

  // remote source slots
  localparam logic [2:0] SLOT_E_APP0 = 3'd0;
  localparam logic [2:0] SLOT_E_APP1 = 3'd1;
  localparam logic [2:0] SLOT_E_ADJ  = 3'd2;
  localparam logic [2:0] SLOT_W_APP0 = 3'd3;
  localparam logic [2:0] SLOT_W_APP1 = 3'd4;
  localparam logic [2:0] SLOT_W_ADJ  = 3'd5;

  // register map (word index)
  localparam logic REG_LOCKOUT_TICKS   = 1'b0;
  localparam logic REG_SIDING_HIGHBALL = 1'b1;
  localparam logic [7:0] LOCKOUT_TICKS_RESET = 8'd50;

  typedef struct packed {
    logic [7:0] occ;
    logic [1:0] east_clr;
    logic [1:0] west_clr;
    logic       east_normal;
    logic       west_normal;
  } sic_state_t;

endpackage

`default_nettype wire

/* rtl/siding_interlocking_controller.sv */
// an accepted request has its result on m_tvalid in the following cycle
// throughput: one request per cycle while the output can take it; the state
// update and aspect logic sit between the state registers and the result
// register; a result waiting in the output register does not stop the next
// request unless m_tready is low; rst (synchronous) clears state, lamps all red
// ----------------------------------------------------------------------------
// siding_interlocking_controller
// Passing-siding interlocking: occupancy, clearances, points and buttons,
// with eight signal aspects reported after every request.
// ----------------------------------------------------------------------------
`default_nettype none

module siding_interlocking_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // local_occupancy[3:0], east_points_normal[4], west_points_normal[5],
  // buttons[9:6], code_end[10], turn_cmd[12:11], clear_cmd[14:13],
  // source_slot[17:15], source_bit[18], zero fill
  input  logic [23:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // east_lamps[7:0], west_lamps[15:8], occupancy_out[23:16],
  // east_clear_out[25:24], west_clear_out[27:26], east_points_cmd[29:28],
  // west_points_cmd[31:30], changed[32], zero fill
  output logic [39:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sic_pkg::*;

  logic [7:0]  lockout_ticks;
  logic        siding_highball;

  sic_state_t  st, st_next;
  logic [3:0]  button_history, button_history_next;
  logic [7:0]  lockout_count, lockout_count_next;
  logic [29:0] last_report, report;

  logic [39:0] out_data;
  logic        out_valid;

  logic        in_fire;
  logic        cfg_write;

  logic [3:0]  in_local_occ, in_buttons;
  logic        in_east_normal, in_west_normal, in_code_end, in_source_bit;
  logic [1:0]  in_turn, in_clear;
  logic [2:0]  in_slot;

  logic [3:0]  fall;
  logic [1:0]  east_cmd, west_cmd, pulse, new_clr;
  logic        os_busy, clr_write;
  logic [7:0]  slot_mask;
  logic [7:0]  east_lamps, west_lamps;

  assign in_local_occ   = s_tdata[3:0];
  assign in_east_normal = s_tdata[4];
  assign in_west_normal = s_tdata[5];
  assign in_buttons     = s_tdata[9:6];
  assign in_code_end    = s_tdata[10];
  assign in_turn        = s_tdata[12:11];
  assign in_clear       = s_tdata[14:13];
  assign in_slot        = s_tdata[17:15];
  assign in_source_bit  = s_tdata[18];

  assign s_tready = !out_valid || m_tready;
  assign in_fire  = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_SIDING_HIGHBALL) ? {31'd0, siding_highball}
                                                        : {24'd0, lockout_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ticks   <= LOCKOUT_TICKS_RESET;
      siding_highball <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == REG_SIDING_HIGHBALL) siding_highball <= pwdata[0];
      else lockout_ticks <= pwdata[7:0];
    end
  end

  always_comb begin
    st_next             = st;
    button_history_next = button_history;
    lockout_count_next  = lockout_count;
    east_cmd            = PULSE_NONE;
    west_cmd            = PULSE_NONE;
    fall                = ~in_buttons & button_history;
    os_busy             = in_code_end ? st.occ[0] : st.occ[1];
    pulse               = PULSE_NONE;
    new_clr             = CLR_NONE;
    clr_write           = 1'b0;
    slot_mask           = 8'd0;
    case (in_slot)
      SLOT_E_APP0, SLOT_E_APP1: slot_mask = OCC_E_APP;
      SLOT_E_ADJ:               slot_mask = OCC_E_ADJ;
      SLOT_W_APP0, SLOT_W_APP1: slot_mask = OCC_W_APP;
      SLOT_W_ADJ:               slot_mask = OCC_W_ADJ;
      default:                  slot_mask = 8'd0;
    endcase
    case (s_tuser)
      KIND_SCAN: begin
        st_next.occ         = {st.occ[7:4], in_local_occ};
        st_next.east_normal = in_east_normal;
        st_next.west_normal = in_west_normal;
        if (lockout_count == 8'd0 && in_buttons != button_history) begin
          // main button wins when both buttons of one end fall
          if (fall[0]) begin
            east_cmd = PULSE_MAIN;
            st_next.east_clr = CLR_NONE;
          end else if (fall[1]) begin
            east_cmd = PULSE_DIV;
            st_next.east_clr = CLR_NONE;
          end
          if (fall[2]) begin
            west_cmd = PULSE_MAIN;
            st_next.west_clr = CLR_NONE;
          end else if (fall[3]) begin
            west_cmd = PULSE_DIV;
            st_next.west_clr = CLR_NONE;
          end
          button_history_next = in_buttons;
          lockout_count_next  = lockout_ticks;
        end
      end
      KIND_TICK: begin
        if (lockout_count != 8'd0) lockout_count_next = lockout_count - 8'd1;
      end
      KIND_ROUTE: begin
        if (!os_busy && (in_turn == TURN_MAIN || in_turn == TURN_DIV)) pulse = in_turn;
        case (in_clear)
          CMD_CLR_EAST: begin
            new_clr   = os_busy ? CLR_NONE : CLR_EAST;
            clr_write = 1'b1;
          end
          CMD_CLR_WEST: begin
            new_clr   = os_busy ? CLR_NONE : CLR_WEST;
            clr_write = 1'b1;
          end
          CMD_CANCEL: begin
            new_clr   = CLR_NONE;
            clr_write = 1'b1;
          end
          default: clr_write = 1'b0;
        endcase
        if (in_code_end) begin
          west_cmd = pulse;
          if (clr_write) st_next.west_clr = new_clr;
        end else begin
          east_cmd = pulse;
          if (clr_write) st_next.east_clr = new_clr;
        end
      end
      KIND_REMOTE: begin
        st_next.occ = in_source_bit ? (st.occ | slot_mask) : (st.occ & ~slot_mask);
      end
      default: st_next = st;
    endcase
    // an occupied os section drops its end's clearance
    if ((st_next.occ & OCC_E_OS) != 8'd0) st_next.east_clr = CLR_NONE;
    if ((st_next.occ & OCC_W_OS) != 8'd0) st_next.west_clr = CLR_NONE;
  end

  sic_aspects u_aspects (
    .st         (st_next),
    .highball   (siding_highball),
    .east_lamps (east_lamps),
    .west_lamps (west_lamps)
  );

  assign report = {st_next.west_normal, st_next.east_normal, st_next.west_clr,
                   st_next.east_clr, st_next.occ, west_lamps, east_lamps};

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= '0;
      button_history <= 4'hF;
      lockout_count  <= 8'd0;
      last_report    <= {14'd0, LAMPS_ALL_RED, LAMPS_ALL_RED};
      out_valid      <= 1'b0;
    end else begin
      if (in_fire) begin
        st             <= st_next;
        button_history <= button_history_next;
        lockout_count  <= lockout_count_next;
        last_report    <= report;
        out_valid      <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= {7'd0, report != last_report, west_cmd, east_cmd,
                   st_next.west_clr, st_next.east_clr, st_next.occ, west_lamps, east_lamps};
    end
  end

`ifndef SYNTHESIS
  a_east_os_cancel: assert property (@(posedge clk) disable iff (rst)
    st.occ[1] |-> st.east_clr == CLR_NONE)
    else $error("east clearance held with east os occupied");

  a_west_os_cancel: assert property (@(posedge clk) disable iff (rst)
    st.occ[0] |-> st.west_clr == CLR_NONE)
    else $error("west clearance held with west os occupied");

  a_lockout_load: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_tuser == KIND_SCAN && lockout_count == 8'd0 &&
    in_buttons != button_history |=> lockout_count == $past(lockout_ticks))
    else $error("lockout not loaded after button change");

  a_tick_keeps_occ: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_tuser == KIND_TICK |=> st.occ == $past(st.occ))
    else $error("tick changed occupancy");
`endif

endmodule

`default_nettype wire

/* rtl/sic_aspects.sv */
// ----------------------------------------------------------------------------
// sic_aspects
// Signal aspect logic: lamp pairs for both ends from occupancy, clearance
// and points positions.
// ----------------------------------------------------------------------------
`default_nettype none

module sic_aspects (
  input  sic_pkg::sic_state_t st,
  input  logic                highball,
  output logic [7:0]          east_lamps,
  output logic [7:0]          west_lamps
);
  import sic_pkg::*;

  function automatic logic [1:0] grade(input logic [7:0] occ, input logic [7:0] stop_m,
                                       input logic [7:0] caut_m);
    logic [1:0] a;
    if ((occ & stop_m) != 8'd0) a = ASP_RED;
    else if ((occ & caut_m) != 8'd0) a = ASP_YELLOW;
    else a = ASP_GREEN;
    return a;
  endfunction

  function automatic logic [7:0] end_lamps(
    input logic [7:0] occ, input logic hb,
    input logic [1:0] near_clr, input logic near_normal,
    input logic [1:0] far_clr, input logic far_normal,
    input logic [1:0] out_dir, input logic [1:0] in_dir,
    input logic [7:0] own_os, input logic [7:0] own_adj, input logic [7:0] own_app,
    input logic [7:0] far_os, input logic [7:0] far_adj);
    logic [1:0] m, s, u, l;
    logic far_busy, far_off;
    m = ASP_RED;
    s = ASP_RED;
    u = ASP_RED;
    l = ASP_RED;
    far_busy = (occ & (far_adj | far_os)) != 8'd0;
    far_off  = far_clr != in_dir;
    if (near_clr == out_dir) begin
      if (near_normal) m = grade(occ, own_adj | own_os, own_app);
      else s = grade(occ, own_adj | own_os, own_app);
    end else if (near_clr == in_dir) begin
      if (near_normal) begin
        if ((occ & (OCC_MAIN | own_os)) != 8'd0) u = ASP_RED;
        else if (far_busy || !far_normal || far_off) u = ASP_YELLOW;
        else u = ASP_GREEN;
      end else begin
        if ((occ & (OCC_SIDE | own_os)) != 8'd0) l = ASP_RED;
        else if (far_busy || far_normal || far_off) l = ASP_YELLOW;
        else l = hb ? ASP_GREEN : ASP_YELLOW;
      end
    end
    return {m, s, u, l};
  endfunction

  assign east_lamps = end_lamps(st.occ, highball, st.east_clr, st.east_normal,
                                st.west_clr, st.west_normal, CLR_EAST, CLR_WEST,
                                OCC_E_OS, OCC_E_ADJ, OCC_E_APP, OCC_W_OS, OCC_W_ADJ);
  assign west_lamps = end_lamps(st.occ, highball, st.west_clr, st.west_normal,
                                st.east_clr, st.east_normal, CLR_WEST, CLR_EAST,
                                OCC_W_OS, OCC_W_ADJ, OCC_W_APP, OCC_E_OS, OCC_E_ADJ);

endmodule

`default_nettype wire

/* tb/sv/sic_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sic_checker
// Watches the request, result and register ports of the siding interlocking
// controller, predicts each result from its own copy of the interlocking
// state and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module sic_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // local_occupancy[3:0], east_points_normal[4], west_points_normal[5],
  // buttons[9:6], code_end[10], turn_cmd[12:11], clear_cmd[14:13],
  // source_slot[17:15], source_bit[18], zero fill
  input  logic [23:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // east_lamps[7:0], west_lamps[15:8], occupancy_out[23:16],
  // east_clear_out[25:24], west_clear_out[27:26], east_points_cmd[29:28],
  // west_points_cmd[31:30], changed[32], zero fill
  input  logic [39:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          failures,
  output int          pending,
  output int          checked
);
  import sic_pkg::*;

  typedef struct packed {
    logic [7:0] east_lamps;
    logic [7:0] west_lamps;
    logic [7:0] occ;
    logic [1:0] east_clr;
    logic [1:0] west_clr;
    logic [1:0] east_cmd;
    logic [1:0] west_cmd;
    logic       changed;
  } aspect_report_t;

  aspect_report_t expected_reports[$];

  // register copies
  logic [7:0]  lockout_ticks_cfg;
  logic        highball_cfg;

  // interlocking state
  logic [7:0]  occ_bits;
  logic [1:0]  east_route;
  logic [1:0]  west_route;
  logic        east_normal;
  logic        west_normal;
  logic [3:0]  button_seen;
  logic [7:0]  lockout_left;
  logic [29:0] last_report;

  function automatic logic [1:0] grade_aspect(input logic [7:0] occ,
                                              input logic [7:0] stop_mask,
                                              input logic [7:0] caution_mask);
    if ((occ & stop_mask) != 8'h00) return ASP_RED;
    if ((occ & caution_mask) != 8'h00) return ASP_YELLOW;
    return ASP_GREEN;
  endfunction

  // near: this end's clearance and points, far: the other end's
  function automatic logic [7:0] end_aspects(
    input logic [7:0] occ, input logic highball,
    input logic [1:0] near_clr, input logic near_norm,
    input logic [1:0] far_clr, input logic far_norm,
    input logic [1:0] out_dir, input logic [1:0] in_dir,
    input logic [7:0] own_os, input logic [7:0] own_adj, input logic [7:0] own_app,
    input logic [7:0] far_os, input logic [7:0] far_adj);
    logic [1:0] main_a, side_a, upper_a, lower_a;
    logic far_busy, far_off;
    main_a = ASP_RED;
    side_a = ASP_RED;
    upper_a = ASP_RED;
    lower_a = ASP_RED;
    far_busy = (occ & (far_adj | far_os)) != 8'h00;
    far_off = far_clr != in_dir;
    if (near_clr == out_dir) begin
      if (near_norm) main_a = grade_aspect(occ, own_adj | own_os, own_app);
      else side_a = grade_aspect(occ, own_adj | own_os, own_app);
    end else if (near_clr == in_dir) begin
      if (near_norm) begin
        if ((occ & (OCC_MAIN | own_os)) != 8'h00) upper_a = ASP_RED;
        else if (far_busy || !far_norm || far_off) upper_a = ASP_YELLOW;
        else upper_a = ASP_GREEN;
      end else begin
        if ((occ & (OCC_SIDE | own_os)) != 8'h00) lower_a = ASP_RED;
        else if (far_busy || far_norm || far_off) lower_a = ASP_YELLOW;
        else lower_a = highball ? ASP_GREEN : ASP_YELLOW;
      end
    end
    return {main_a, side_a, upper_a, lower_a};
  endfunction

  task automatic advance_interlocking(input logic [1:0] kind, input logic [23:0] d);
    aspect_report_t r;
    logic [29:0] report;
    logic [3:0] fall;
    logic [1:0] pulse, new_clr;
    logic [7:0] slot_mask;
    logic os_busy, write_clr;
    r = '0;
    case (kind)
      KIND_SCAN: begin
        occ_bits = {occ_bits[7:4], d[3:0]};
        east_normal = d[4];
        west_normal = d[5];
        if (lockout_left == 8'd0 && d[9:6] != button_seen) begin
          fall = (d[9:6] ^ button_seen) & button_seen;
          // main button wins when both of one end fall
          if (fall[0]) begin
            r.east_cmd = PULSE_MAIN;
            east_route = CLR_NONE;
          end else if (fall[1]) begin
            r.east_cmd = PULSE_DIV;
            east_route = CLR_NONE;
          end
          if (fall[2]) begin
            r.west_cmd = PULSE_MAIN;
            west_route = CLR_NONE;
          end else if (fall[3]) begin
            r.west_cmd = PULSE_DIV;
            west_route = CLR_NONE;
          end
          button_seen = d[9:6];
          lockout_left = lockout_ticks_cfg;
        end
      end
      KIND_TICK: begin
        if (lockout_left != 8'd0) lockout_left = lockout_left - 8'd1;
      end
      KIND_ROUTE: begin
        os_busy = (occ_bits & (d[10] ? OCC_W_OS : OCC_E_OS)) != 8'h00;
        pulse = PULSE_NONE;
        if (!os_busy && (d[12:11] == TURN_MAIN || d[12:11] == TURN_DIV)) pulse = d[12:11];
        write_clr = 1'b1;
        new_clr = CLR_NONE;
        if (d[14:13] == CMD_CLR_EAST && !os_busy) new_clr = CLR_EAST;
        else if (d[14:13] == CMD_CLR_WEST && !os_busy) new_clr = CLR_WEST;
        else if (d[14:13] == CMD_KEEP) write_clr = 1'b0;
        if (d[10]) begin
          r.west_cmd = pulse;
          if (write_clr) west_route = new_clr;
        end else begin
          r.east_cmd = pulse;
          if (write_clr) east_route = new_clr;
        end
      end
      default: begin
        case (d[17:15])
          SLOT_E_APP0, SLOT_E_APP1: slot_mask = OCC_E_APP;
          SLOT_E_ADJ: slot_mask = OCC_E_ADJ;
          SLOT_W_APP0, SLOT_W_APP1: slot_mask = OCC_W_APP;
          SLOT_W_ADJ: slot_mask = OCC_W_ADJ;
          default: slot_mask = 8'h00;
        endcase
        if (d[18]) occ_bits = occ_bits | slot_mask;
        else occ_bits = occ_bits & ~slot_mask;
      end
    endcase

    // occupied os section drops its clearance
    if ((occ_bits & OCC_E_OS) != 8'h00) east_route = CLR_NONE;
    if ((occ_bits & OCC_W_OS) != 8'h00) west_route = CLR_NONE;

    r.east_lamps = end_aspects(occ_bits, highball_cfg, east_route, east_normal,
                               west_route, west_normal, CLR_EAST, CLR_WEST,
                               OCC_E_OS, OCC_E_ADJ, OCC_E_APP, OCC_W_OS, OCC_W_ADJ);
    r.west_lamps = end_aspects(occ_bits, highball_cfg, west_route, west_normal,
                               east_route, east_normal, CLR_WEST, CLR_EAST,
                               OCC_W_OS, OCC_W_ADJ, OCC_W_APP, OCC_E_OS, OCC_E_ADJ);
    r.occ = occ_bits;
    r.east_clr = east_route;
    r.west_clr = west_route;
    report = {west_normal, east_normal, west_route, east_route, occ_bits,
              r.west_lamps, r.east_lamps};
    r.changed = report != last_report;
    last_report = report;
    expected_reports.push_back(r);
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    aspect_report_t want;
    if (rst) begin
      lockout_ticks_cfg = LOCKOUT_TICKS_RESET;
      highball_cfg = 1'b0;
      occ_bits = 8'h00;
      east_route = CLR_NONE;
      west_route = CLR_NONE;
      east_normal = 1'b0;
      west_normal = 1'b0;
      button_seen = 4'hF;
      lockout_left = 8'd0;
      last_report = {14'd0, LAMPS_ALL_RED, LAMPS_ALL_RED};
      expected_reports.delete();
      failures = 0;
      checked = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        if (paddr[2] == REG_LOCKOUT_TICKS) lockout_ticks_cfg = pwdata[7:0];
        else highball_cfg = pwdata[0];
      end
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, m_tdata);
          failures++;
        end else begin
          want = expected_reports.pop_front();
          check_field("east_lamps", want.east_lamps, m_tdata[7:0]);
          check_field("west_lamps", want.west_lamps, m_tdata[15:8]);
          check_field("occupancy_out", want.occ, m_tdata[23:16]);
          check_field("east_clear_out", 8'(want.east_clr), 8'(m_tdata[25:24]));
          check_field("west_clear_out", 8'(want.west_clr), 8'(m_tdata[27:26]));
          check_field("east_points_cmd", 8'(want.east_cmd), 8'(m_tdata[29:28]));
          check_field("west_points_cmd", 8'(want.west_cmd), 8'(m_tdata[31:30]));
          check_field("changed", 8'(want.changed), 8'(m_tdata[32]));
          checked++;
        end
      end
      if (s_tvalid && s_tready) advance_interlocking(s_tuser, s_tdata);
    end
    pending = expected_reports.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives scans, ticks, route codes and remote occupancy into the siding
// interlocking controller under random idling on both sides, across several
// register settings, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module testbench;
  import sic_pkg::*;

  localparam logic [2:0] LOCKOUT_ADDR  = {REG_LOCKOUT_TICKS, 2'b00};
  localparam logic [2:0] HIGHBALL_ADDR = {REG_SIDING_HIGHBALL, 2'b00};
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = KIND_SCAN;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int   failures, pending, checked;
  int   kind_count[4];
  int   settings;
  logic quiet = 1'b0;
  logic [3:0] panel_buttons = 4'hF;

  logic [7:0] phase_lockout[PHASES] = '{8'd0, 8'd3, 8'd255, 8'd1, 8'd7};
  logic       phase_highball[PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  siding_interlocking_controller dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sic_checker aspect_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .failures(failures), .pending(pending), .checked(checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 27);
  end

  initial begin
    #2_000_000;
    $display("siding_interlocking_controller regression: fail");
    $finish;
  end

  // fields foreign to the item's kind carry random noise
  function automatic logic [23:0] filler_word();
    return {5'b0, 19'($urandom)};
  endfunction

  function automatic logic [23:0] scan_word(input logic [3:0] occ, input logic east_norm,
                                            input logic west_norm, input logic [3:0] btn);
    logic [23:0] d;
    d = filler_word();
    d[3:0] = occ;
    d[4] = east_norm;
    d[5] = west_norm;
    d[9:6] = btn;
    return d;
  endfunction

  function automatic logic [23:0] route_word(input logic west_end, input logic [1:0] turn,
                                             input logic [1:0] clr);
    logic [23:0] d;
    d = filler_word();
    d[10] = west_end;
    d[12:11] = turn;
    d[14:13] = clr;
    return d;
  endfunction

  function automatic logic [23:0] remote_word(input logic [2:0] slot, input logic occupied);
    logic [23:0] d;
    d = filler_word();
    d[17:15] = slot;
    d[18] = occupied;
    return d;
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic [23:0] d);
    if (!quiet && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    kind_count[kind]++;
  endtask

  // hold off until every result has come back
  task automatic wait_settled();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    settings++;
  endtask

  task automatic random_request();
    logic [3:0] occ;
    int pick, b;
    pick = $urandom_range(99);
    if (pick < 30) begin
      // track mostly clear so clearances survive, buttons pressed now and then
      for (int i = 0; i < 4; i++) occ[i] = ($urandom_range(4) == 0);
      if ($urandom_range(99) < 5) begin
        panel_buttons = 4'($urandom);
      end else if ($urandom_range(99) < 20) begin
        b = $urandom_range(3);
        panel_buttons[b] = ~panel_buttons[b];
      end
      send_request(KIND_SCAN, scan_word(occ, 1'($urandom_range(1)), 1'($urandom_range(1)),
                                        panel_buttons));
    end else if (pick < 55) begin
      send_request(KIND_TICK, filler_word());
    end else if (pick < 85) begin
      send_request(KIND_ROUTE, route_word(1'($urandom_range(1)), 2'($urandom_range(3)),
                                          2'($urandom_range(3))));
    end else begin
      send_request(KIND_REMOTE, remote_word(3'($urandom_range(7)), $urandom_range(2) == 0));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: long lockout, no highball
    send_request(KIND_TICK, filler_word());
    send_request(KIND_SCAN, scan_word(4'h0, 1'b1, 1'b1, 4'hF));
    send_request(KIND_ROUTE, route_word(1'b0, TURN_MAIN, CMD_CLR_EAST));
    send_request(KIND_ROUTE, route_word(1'b1, TURN_MAIN, CMD_CLR_EAST));
    send_request(KIND_SCAN, scan_word(4'h0, 1'b1, 1'b1, 4'b1100));
    send_request(KIND_SCAN, scan_word(4'h0, 1'b1, 1'b1, 4'b0000));
    wait_settled();
    write_register(LOCKOUT_ADDR, 32'd2);
    write_register(HIGHBALL_ADDR, 32'd1);

    send_request(KIND_TICK, filler_word());
    send_request(KIND_TICK, filler_word());
    send_request(KIND_TICK, filler_word());
    send_request(KIND_SCAN, scan_word(4'h0, 1'b1, 1'b1, 4'b0011));
    send_request(KIND_TICK, filler_word());
    send_request(KIND_TICK, filler_word());
    send_request(KIND_SCAN, scan_word(4'h0, 1'b0, 1'b0, 4'hF));
    // both ends reversed and cleared westward: siding entry may show green
    send_request(KIND_ROUTE, route_word(1'b0, TURN_DIV, CMD_CLR_WEST));
    send_request(KIND_ROUTE, route_word(1'b1, 2'd3, CMD_CLR_WEST));
    send_request(KIND_REMOTE, remote_word(SLOT_W_ADJ, 1'b1));
    send_request(KIND_REMOTE, remote_word(3'd6, 1'b1));
    send_request(KIND_REMOTE, remote_word(3'd7, 1'b1));
    send_request(KIND_REMOTE, remote_word(SLOT_E_APP1, 1'b1));
    send_request(KIND_REMOTE, remote_word(SLOT_E_ADJ, 1'b1));
    send_request(KIND_REMOTE, remote_word(SLOT_W_APP0, 1'b1));
    send_request(KIND_SCAN, scan_word(4'hF, 1'b1, 1'b1, 4'hF));
    send_request(KIND_ROUTE, route_word(1'b0, TURN_MAIN, CMD_CLR_EAST));

    for (int p = 0; p < PHASES; p++) begin
      wait_settled();
      write_register(LOCKOUT_ADDR, {24'd0, phase_lockout[p]});
      write_register(HIGHBALL_ADDR, {31'd0, phase_highball[p]});
      quiet = (p == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) random_request();
    end
    quiet = 1'b0;

    wait_settled();
    repeat (4) @(posedge clk);
    $display("covered %0d requests: %0d scans, %0d ticks, %0d route codes, %0d remote bits",
             kind_count[KIND_SCAN] + kind_count[KIND_TICK] + kind_count[KIND_ROUTE]
             + kind_count[KIND_REMOTE], kind_count[KIND_SCAN], kind_count[KIND_TICK],
             kind_count[KIND_ROUTE], kind_count[KIND_REMOTE]);
    $display("%0d register writes, lockout 0 to 255, highball on and off, %0d results checked",
             settings, checked);
    if (failures == 0) begin
      $display("siding_interlocking_controller regression: pass");
    end else begin
      $display("siding_interlocking_controller regression: fail");
    end
    $finish;
  end

endmodule
